### design/pidc_pkg.sv
package pidc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TICKS_PER_SECOND_DEF = 1000;

    // Accumulator width: the reciprocal product for the integral increment is below 2^129,
    // and the three gain products sum to less than 2^88.
    localparam int ACC_W = 130;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_DERIVED  = 2'd1,
        ACT_SUPPLIED = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MAX = 3'd4
    } t_reg_index;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL1  = 11'b000_0000_0010,
        S_RECIP = 11'b000_0000_0100,
        S_INTEG = 11'b000_0000_1000,
        S_MUL2  = 11'b000_0001_0000,
        S_DIV2  = 11'b000_0010_0000,
        S_GP    = 11'b000_0100_0000,
        S_GI    = 11'b000_1000_0000,
        S_GD    = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } t_state;

endpackage

### design/pid_controller_clamped.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_action, i_setpoint, i_feedback, i_feedback_rate,
//                                         i_time_ms
// output    out        o_valid / i_stall  o_drive, o_clamped, o_zero_interval
// config    in         APB write/read     paddr, pwdata, prdata
//
// A start transfer only records the time and leaves the sequencer idle. After a compute
// transfer it runs in order: shift-add multiplies by the interval and by the 65-bit
// reciprocal of TICKS_PER_SECOND, the integral update, a multiply by TICKS_PER_SECOND
// and a serial division by the interval (both skipped when the derivative is supplied
// or the interval is zero), multiplies by the three gain magnitudes and the clamp. Each
// multiply steps through the significant bits of its operand. One shared 130-bit adder
// serves every multiply and divide step. The clamp waits while a result is held by
// i_stall. Reset is synchronous and active low; it resets the controller state, the
// output valid and config registers. o_stall is high while an item is in work; a finished
// result waits in the output register, and a new transfer is taken while it waits.
module pid_controller_clamped #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
    parameter int TICKS_PER_SECOND = pidc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic signed [31:0]         i_setpoint,
    input  logic signed [31:0]         i_feedback,
    input  logic signed [31:0]         i_feedback_rate,
    input  logic [31:0]                i_time_ms,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_drive,
    output logic                       o_clamped,
    output logic                       o_zero_interval,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pidc_pkg::*;

    localparam int W = ACC_W;
    localparam logic [31:0] TPS_C = 32'(TICKS_PER_SECOND);

    // Division of a 64-bit product by TICKS_PER_SECOND is a multiply by a rounded-up
    // reciprocal followed by a right shift; with the shift 64 plus the ceiling of log2 of
    // the divisor, the quotient is exact for every 64-bit dividend.
    localparam int RECIP_SH = 64 + $clog2(TICKS_PER_SECOND);
    localparam logic [84:0] RECIP_ONE = 85'(1) << RECIP_SH;
    localparam logic [64:0] RECIP_M =
        65'((RECIP_ONE + 85'(TICKS_PER_SECOND - 1)) / 85'(TICKS_PER_SECOND));

    // Configuration registers.
    logic [31:0] r_gain_p, r_gain_i, r_gain_d, r_drive_min, r_drive_max;

    // Controller state carried from item to item.
    logic [31:0]        r_last_time;
    logic signed [47:0] r_integ, n_integ;
    logic signed [32:0] r_last_err, n_last_err;

    // Sequencer and shared unit.
    t_state             r_state, n_state;
    logic [W-1:0]       r_acc, n_acc, r_a, n_a;
    logic [64:0]        r_b, n_b;
    logic               r_neg, n_neg;
    logic [63:0]        r_num, n_num;
    logic [32:0]        r_rem, n_rem;
    logic [31:0]        r_dvs, n_dvs;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // The item in work.
    logic signed [32:0] r_err;
    logic [31:0]        r_dt;
    logic               r_supplied;
    logic signed [31:0] r_rate;
    logic               r_dneg, n_dneg;
    logic signed [54:0] r_dterm, n_dterm;
    logic               r_zflag, n_zflag;

    // Output register.
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_drive, n_drive;
    logic               r_clamped, n_clamped, r_zero, n_zero;

    // The one adder/subtractor that every multiply and divide step goes through.
    logic [W-1:0] add_x, add_y, add_sum;
    logic         add_sub;
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + W'(add_sub);

    logic in_take, cfg_wr;
    assign o_stall = (r_state != S_IDLE);
    assign in_take = i_valid && !o_stall;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (t_reg_index'(paddr[4:2]))
            REG_GAIN_P:    prdata = r_gain_p;
            REG_GAIN_I:    prdata = r_gain_i;
            REG_GAIN_D:    prdata = r_gain_d;
            REG_DRIVE_MIN: prdata = r_drive_min;
            REG_DRIVE_MAX: prdata = r_drive_max;
            default:       prdata = '0;
        endcase
    end

    // Magnitudes and signs of the operands fed to the multiplier.
    logic [32:0] err_mag;
    logic [47:0] integ_mag;
    logic [54:0] dterm_mag;
    logic [31:0] gp_mag, gi_mag, gd_mag;
    logic signed [33:0] diff;
    logic [33:0] diff_mag;
    assign err_mag   = r_err[32] ? 33'(-r_err) : 33'(r_err);
    assign integ_mag = r_integ[47] ? 48'(-r_integ) : 48'(r_integ);
    assign dterm_mag = r_dterm[54] ? 55'(-r_dterm) : 55'(r_dterm);
    assign gp_mag    = r_gain_p[31] ? 32'(-r_gain_p) : r_gain_p;
    assign gi_mag    = r_gain_i[31] ? 32'(-r_gain_i) : r_gain_i;
    assign gd_mag    = r_gain_d[31] ? 32'(-r_gain_d) : r_gain_d;
    assign diff      = 34'(r_err) - 34'(r_last_err);
    assign diff_mag  = diff[33] ? 34'(-diff) : 34'(diff);

    // Integral update: saturate the increment to 2^48, the sum to 48 bits.
    logic [48:0]        imag;
    logic signed [49:0] inc, isum;
    logic signed [47:0] isat;
    assign imag = (r_num > 64'(49'h1_0000_0000_0000)) ? 49'h1_0000_0000_0000 : r_num[48:0];
    assign inc  = r_err[32] ? -50'(imag) : 50'(imag);
    assign isum = 50'(r_integ) + inc;
    always_comb begin
        if (isum > 50'sh0_7FFF_FFFF_FFFF)
            isat = 48'sh7FFF_FFFF_FFFF;
        else if (isum < -50'sh0_8000_0000_0000)
            isat = 48'sh8000_0000_0000;
        else
            isat = isum[47:0];
    end

    // Divide step: shift one dividend bit into the partial remainder and try the divisor.
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {r_rem[31:0], r_num[63]};
    assign q_bit  = !add_sum[W-1];

    // Final scaling and clamp. The arithmetic shift rounds toward minus infinity.
    logic signed [W-1:0] scaled, lo_w, hi_w;
    assign scaled = $signed(r_acc) >>> FRAC_BITS;
    assign lo_w   = W'($signed(r_drive_min));
    assign hi_w   = W'($signed(r_drive_max));

    logic [63:0] q_final;
    assign q_final = {r_num[62:0], q_bit};

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_a        = r_a;
        n_b        = r_b;
        n_neg      = r_neg;
        n_num      = r_num;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_cnt      = r_cnt;
        n_integ    = r_integ;
        n_last_err = r_last_err;
        n_dneg     = r_dneg;
        n_dterm    = r_dterm;
        n_zflag    = r_zflag;
        n_drive    = r_drive;
        n_clamped  = r_clamped;
        n_zero     = r_zero;
        n_ovalid   = r_ovalid && i_stall;
        add_x      = r_acc;
        add_y      = r_a;
        add_sub    = r_neg;

        case (r_state)
            S_IDLE: begin
                if (in_take && (i_action == ACT_DERIVED || i_action == ACT_SUPPLIED)) begin
                    // err and dt are registered at the same edge; start |err| * dt.
                    n_state = S_MUL1;
                    n_acc   = '0;
                    n_a     = W'(i_setpoint[31] ^ i_feedback[31] ?
                              ((33'($signed(i_setpoint)) - 33'($signed(i_feedback))) < 0 ?
                               33'(-(33'($signed(i_setpoint)) - 33'($signed(i_feedback)))) :
                               33'(33'($signed(i_setpoint)) - 33'($signed(i_feedback)))) :
                              ((33'($signed(i_setpoint)) - 33'($signed(i_feedback))) < 0 ?
                               33'(-(33'($signed(i_setpoint)) - 33'($signed(i_feedback)))) :
                               33'(33'($signed(i_setpoint)) - 33'($signed(i_feedback)))));
                    n_b     = {33'b0, i_time_ms - r_last_time};
                    n_neg   = 1'b0;
                    n_zflag = 1'b0;
                end
            end
            S_MUL1, S_RECIP, S_MUL2, S_GP, S_GI, S_GD: begin
                if (r_b != '0) begin
                    if (r_b[0])
                        n_acc = add_sum;
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end else begin
                    case (r_state)
                        S_MUL1: begin
                            // |err| * dt is below 2^64; scale it by the reciprocal next.
                            n_state = S_RECIP;
                            n_acc   = '0;
                            n_a     = W'(r_acc[63:0]);
                            n_b     = RECIP_M;
                            n_neg   = 1'b0;
                        end
                        S_RECIP: begin
                            n_state = S_INTEG;
                            n_num   = 64'(r_acc >> RECIP_SH);
                        end
                        S_MUL2: begin
                            n_state = S_DIV2;
                            n_num   = r_acc[63:0];
                            n_rem   = '0;
                            n_dvs   = r_dt;
                            n_cnt   = '0;
                        end
                        S_GP: begin
                            n_state = S_GI;
                            n_a     = W'(integ_mag);
                            n_b     = 65'(gi_mag);
                            n_neg   = r_integ[47] ^ r_gain_i[31];
                        end
                        S_GI: begin
                            n_state = S_GD;
                            n_a     = W'(dterm_mag);
                            n_b     = 65'(gd_mag);
                            n_neg   = r_dterm[54] ^ r_gain_d[31];
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV2: begin
                add_x   = W'(rem_sh);
                add_y   = W'(r_dvs);
                add_sub = 1'b1;
                n_rem   = q_bit ? add_sum[32:0] : rem_sh;
                n_num   = q_final;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_dterm = r_dneg ? -55'(q_final[54:0]) : 55'(q_final[54:0]);
                    n_state = S_GP;
                    n_acc   = '0;
                    n_a     = W'(err_mag);
                    n_b     = 65'(gp_mag);
                    n_neg   = r_err[32] ^ r_gain_p[31];
                end
            end
            S_INTEG: begin
                n_integ    = isat;
                n_last_err = r_err;
                if (r_supplied || r_dt == '0) begin
                    n_dterm = r_supplied ? 55'(r_rate) : '0;
                    n_zflag = !r_supplied;
                    n_state = S_GP;
                    n_acc   = '0;
                    n_a     = W'(err_mag);
                    n_b     = 65'(gp_mag);
                    n_neg   = r_err[32] ^ r_gain_p[31];
                end else begin
                    n_state = S_MUL2;
                    n_acc   = '0;
                    n_a     = W'(diff_mag);
                    n_b     = 65'(TPS_C);
                    n_neg   = 1'b0;
                    n_dneg  = diff[33];
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_zero   = r_zflag;
                    if (scaled < lo_w) begin
                        n_drive   = r_drive_min;
                        n_clamped = 1'b1;
                    end else if (scaled > hi_w) begin
                        n_drive   = r_drive_max;
                        n_clamped = 1'b1;
                    end else begin
                        n_drive   = scaled[31:0];
                        n_clamped = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_drive_min <= 32'h8000_0000;
            r_drive_max <= 32'h7FFF_FFFF;
            r_last_time <= '0;
            r_integ     <= '0;
            r_last_err  <= '0;
        end else begin
            r_state    <= n_state;
            r_ovalid   <= n_ovalid;
            r_integ    <= n_integ;
            r_last_err <= n_last_err;
            if (in_take && i_action != ACT_UNUSED)
                r_last_time <= i_time_ms;
            if (cfg_wr) begin
                case (t_reg_index'(paddr[4:2]))
                    REG_GAIN_P:    r_gain_p    <= pwdata;
                    REG_GAIN_I:    r_gain_i    <= pwdata;
                    REG_GAIN_D:    r_gain_d    <= pwdata;
                    REG_DRIVE_MIN: r_drive_min <= pwdata;
                    REG_DRIVE_MAX: r_drive_max <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_a       <= n_a;
        r_b       <= n_b;
        r_neg     <= n_neg;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_dneg    <= n_dneg;
        r_dterm   <= n_dterm;
        r_zflag   <= n_zflag;
        r_drive   <= n_drive;
        r_clamped <= n_clamped;
        r_zero    <= n_zero;
        if (in_take) begin
            r_err      <= 33'($signed(i_setpoint)) - 33'($signed(i_feedback));
            r_dt       <= i_time_ms - r_last_time;
            r_supplied <= (i_action == ACT_SUPPLIED);
            r_rate     <= i_feedback_rate;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_drive         = r_drive;
    assign o_clamped       = r_clamped;
    assign o_zero_interval = r_zero;

endmodule
